>>> hdl/quadratic_polynomial_roots_macros.svh
// assertion macros for the quadratic root solver
// used by the port checker; no other dependencies
`ifndef QUADRATIC_POLYNOMIAL_ROOTS_MACROS_SVH
`define QUADRATIC_POLYNOMIAL_ROOTS_MACROS_SVH

// same-cycle implication, disabled during reset
`define QPR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define QPR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/qpr_pkg.sv
// shared widths, types and the saturation helper for the quadratic root solver
// no dependencies; used by every module of the block
package qpr_pkg;

  localparam int CW        = 32;          // coefficient and root width
  localparam int FB        = 16;          // fractional bits
  localparam int PW        = 2 * CW;      // product width
  localparam int DW        = PW + 2;      // discriminant width, even
  localparam int SQ_STEPS  = DW / 2;      // square root stages
  localparam int RW        = SQ_STEPS;    // root width
  localparam int REMW      = RW + 2;      // square root remainder width
  localparam int QMW       = RW + 1;      // |b| + sqrt(D) width
  localparam int NUMW      = QMW + FB;    // dividend width
  localparam int DENW      = QMW;         // divisor width
  localparam int DIV_STEPS = NUMW;        // divider stages
  localparam int IN_W      = 3 * CW;
  localparam int OUT_W     = ((4 * CW + 3 + 7) / 8) * 8;

  typedef enum logic [2:0] {
    CLS_DEGEN  = 3'd0,
    CLS_LINEAR = 3'd1,
    CLS_ZERO   = 3'd2,
    CLS_QUAD   = 3'd3,
    CLS_REAL   = 3'd4,
    CLS_CPLX   = 3'd5
  } cls_t;

  // context carried beside the square root pipe
  typedef struct packed {
    cls_t          cls;
    logic          na;
    logic          nb;
    logic          nc;
    logic [CW-1:0] ma;
    logic [CW-1:0] mb;
    logic [CW-1:0] mc;
    logic          dneg;
  } sq_ctx_t;

  // context carried beside the dividers
  typedef struct packed {
    cls_t cls;
    logic na;
    logic nb;
    logic neg0;
    logic neg1;
    logic dz1;
  } dv_ctx_t;

  typedef struct packed {
    logic          sat;
    logic [CW-1:0] val;
  } clip_t;

  // clip a magnitude to the signed range and apply the sign
  function automatic clip_t clip_mag(logic neg, logic [NUMW-1:0] m);
    logic [NUMW-1:0] lim;
    logic [NUMW-1:0] v;
    clip_t           r;
    lim = neg ? (NUMW'(1) << (CW - 1)) : ((NUMW'(1) << (CW - 1)) - NUMW'(1));
    r.sat = (m > lim);
    v = r.sat ? lim : m;
    r.val = neg ? (~v[CW-1:0] + CW'(1)) : v[CW-1:0];
    return r;
  endfunction

endpackage

>>> hdl/qpr_front.sv
// front stages: sign split, classification, products and discriminant
// depends on qpr_pkg
module qpr_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      ce,
  input  logic                      in_valid,
  input  logic [qpr_pkg::CW-1:0]    coef_a,
  input  logic [qpr_pkg::CW-1:0]    coef_b,
  input  logic [qpr_pkg::CW-1:0]    coef_c,
  output logic                      out_valid,
  output qpr_pkg::sq_ctx_t          out_ctx,
  output logic [qpr_pkg::DW-1:0]    out_rad
);

  logic                  v1, v2, v3;
  qpr_pkg::sq_ctx_t      ctx1, ctx1_next, ctx2, ctx3, ctx3_next;
  logic [qpr_pkg::PW-1:0] bb2, ac2;
  logic [qpr_pkg::DW-1:0] rad3, rad3_next;
  logic [qpr_pkg::DW-1:0] ac4, bbw;

  // sign and magnitude split, case classification
  always_comb begin
    ctx1_next.na   = coef_a[qpr_pkg::CW-1];
    ctx1_next.nb   = coef_b[qpr_pkg::CW-1];
    ctx1_next.nc   = coef_c[qpr_pkg::CW-1];
    ctx1_next.ma   = coef_a[qpr_pkg::CW-1] ? (~coef_a + qpr_pkg::CW'(1)) : coef_a;
    ctx1_next.mb   = coef_b[qpr_pkg::CW-1] ? (~coef_b + qpr_pkg::CW'(1)) : coef_b;
    ctx1_next.mc   = coef_c[qpr_pkg::CW-1] ? (~coef_c + qpr_pkg::CW'(1)) : coef_c;
    ctx1_next.dneg = 1'b0;
    if (coef_a == '0) begin
      ctx1_next.cls = (coef_b == '0) ? qpr_pkg::CLS_DEGEN : qpr_pkg::CLS_LINEAR;
    end else begin
      ctx1_next.cls = (coef_b == '0 && coef_c == '0) ? qpr_pkg::CLS_ZERO : qpr_pkg::CLS_QUAD;
    end
  end

  // discriminant magnitude and sign
  always_comb begin
    ac4       = {ac2, 2'b00};
    bbw       = {2'b00, bb2};
    ctx3_next = ctx2;
    if (ctx2.na != ctx2.nc) begin
      rad3_next      = bbw + ac4;
      ctx3_next.dneg = 1'b0;
    end else if (bbw >= ac4) begin
      rad3_next      = bbw - ac4;
      ctx3_next.dneg = 1'b0;
    end else begin
      rad3_next      = ac4 - bbw;
      ctx3_next.dneg = 1'b1;
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (ce) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (ce) begin
      ctx1 <= ctx1_next;
      ctx2 <= ctx1;
      bb2  <= ctx1.mb * ctx1.mb;
      ac2  <= ctx1.ma * ctx1.mc;
      ctx3 <= ctx3_next;
      rad3 <= rad3_next;
    end
  end

  assign out_valid = v3;
  assign out_ctx   = ctx3;
  assign out_rad   = rad3;

endmodule

>>> hdl/qpr_sqrt.sv
// pipelined floor square root, two radicand bits per stage
// depends on qpr_pkg
module qpr_sqrt (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   ce,
  input  logic                   in_valid,
  input  qpr_pkg::sq_ctx_t       in_ctx,
  input  logic [qpr_pkg::DW-1:0] in_rad,
  output logic                   out_valid,
  output qpr_pkg::sq_ctx_t       out_ctx,
  output logic [qpr_pkg::RW-1:0] out_root
);

  logic                     v    [0:qpr_pkg::SQ_STEPS];
  qpr_pkg::sq_ctx_t         ctx  [0:qpr_pkg::SQ_STEPS];
  logic [qpr_pkg::DW-1:0]   rad  [0:qpr_pkg::SQ_STEPS];
  logic [qpr_pkg::REMW-1:0] rem  [0:qpr_pkg::SQ_STEPS];
  logic [qpr_pkg::RW-1:0]   root [0:qpr_pkg::SQ_STEPS];

  assign v[0]    = in_valid;
  assign ctx[0]  = in_ctx;
  assign rad[0]  = in_rad;
  assign rem[0]  = '0;
  assign root[0] = '0;

  for (genvar k = 0; k < qpr_pkg::SQ_STEPS; k++) begin : g_stage
    logic [qpr_pkg::REMW+1:0] rem_sh, trial;
    logic                     fit;

    // one result bit: try (root << 2) | 1 against the shifted remainder
    always_comb begin
      rem_sh = {rem[k], rad[k][qpr_pkg::DW-1:qpr_pkg::DW-2]};
      trial  = {1'b0, root[k], 2'b01};
      fit    = (rem_sh >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (ce) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        ctx[k+1]  <= ctx[k];
        rad[k+1]  <= rad[k] << 2;
        rem[k+1]  <= fit ? qpr_pkg::REMW'(rem_sh - trial) : rem_sh[qpr_pkg::REMW-1:0];
        root[k+1] <= {root[k][qpr_pkg::RW-2:0], fit};
      end
    end
  end

  assign out_valid = v[qpr_pkg::SQ_STEPS];
  assign out_ctx   = ctx[qpr_pkg::SQ_STEPS];
  assign out_root  = root[qpr_pkg::SQ_STEPS];

endmodule

>>> hdl/qpr_div.sv
// pipelined restoring divider, one quotient bit per stage
// depends on qpr_pkg
module qpr_div (
  input  logic                     clk,
  input  logic                     ce,
  input  logic [qpr_pkg::NUMW-1:0] num,
  input  logic [qpr_pkg::DENW-1:0] den,
  output logic [qpr_pkg::NUMW-1:0] quo
);

  logic [qpr_pkg::NUMW-1:0] nq  [0:qpr_pkg::DIV_STEPS];
  logic [qpr_pkg::DENW-1:0] rem [0:qpr_pkg::DIV_STEPS];
  logic [qpr_pkg::DENW-1:0] dv  [0:qpr_pkg::DIV_STEPS];

  assign nq[0]  = num;
  assign rem[0] = '0;
  assign dv[0]  = den;

  for (genvar k = 0; k < qpr_pkg::DIV_STEPS; k++) begin : g_stage
    logic [qpr_pkg::DENW:0] rem_sh;
    logic                   fit;

    // shift in the next dividend bit, subtract when it fits
    always_comb begin
      rem_sh = {rem[k], nq[k][qpr_pkg::NUMW-1]};
      fit    = (rem_sh >= {1'b0, dv[k]});
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        rem[k+1] <= fit ? qpr_pkg::DENW'(rem_sh - {1'b0, dv[k]})
                        : rem_sh[qpr_pkg::DENW-1:0];
        nq[k+1]  <= {nq[k][qpr_pkg::NUMW-2:0], fit};
        dv[k+1]  <= dv[k];
      end
    end
  end

  assign quo = nq[qpr_pkg::DIV_STEPS];

endmodule

>>> hdl/qpr_back.sv
// result assembly with saturation, output register and skid stage
// depends on qpr_pkg
module qpr_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  qpr_pkg::dv_ctx_t          in_ctx,
  input  logic [qpr_pkg::NUMW-1:0]  q0,
  input  logic [qpr_pkg::NUMW-1:0]  q1,
  output logic                      stall,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [qpr_pkg::OUT_W-1:0] m_tdata,
  output logic [0:0]                m_tuser
);

  typedef struct packed {
    logic [qpr_pkg::CW-1:0] imag_second;
    logic [qpr_pkg::CW-1:0] imag_first;
    logic [qpr_pkg::CW-1:0] real_second;
    logic [qpr_pkg::CW-1:0] real_first;
    logic [1:0]             root_count;
    logic                   saturated;
    logic                   status;
  } res_t;

  res_t            res, obuf, sbuf;
  logic            ov, sv, arrive, take;
  qpr_pkg::clip_t  c0, c1, cim1, cim2;
  logic [qpr_pkg::NUMW-1:0] q1z;

  // saturate the quotients
  always_comb begin
    q1z  = in_ctx.dz1 ? '0 : q1;
    c0   = qpr_pkg::clip_mag(in_ctx.neg0, q0);
    c1   = qpr_pkg::clip_mag(in_ctx.neg1, q1z);
    cim1 = qpr_pkg::clip_mag(in_ctx.na, q1);
    cim2 = qpr_pkg::clip_mag(!in_ctx.na, q1);
  end

  // pick fields by case
  always_comb begin
    res = '0;
    unique case (in_ctx.cls)
      qpr_pkg::CLS_DEGEN: begin
        res.status = 1'b1;
      end
      qpr_pkg::CLS_LINEAR: begin
        res.root_count = 2'd1;
        res.real_first = c0.val;
        res.saturated  = c0.sat;
      end
      qpr_pkg::CLS_ZERO: begin
        res.root_count = 2'd1;
      end
      qpr_pkg::CLS_REAL: begin
        res.root_count  = 2'd2;
        res.real_first  = in_ctx.nb ? c1.val : c0.val;
        res.real_second = in_ctx.nb ? c0.val : c1.val;
        res.saturated   = c0.sat | c1.sat;
      end
      qpr_pkg::CLS_CPLX: begin
        res.root_count  = 2'd2;
        res.real_first  = c0.val;
        res.real_second = c0.val;
        res.imag_first  = cim1.val;
        res.imag_second = cim2.val;
        res.saturated   = c0.sat | cim1.sat | cim2.sat;
      end
      default: begin
        res = '0;
      end
    endcase
  end

  assign arrive = in_valid & ~sv;
  assign take   = ov & m_tready;

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (sv) begin
      if (take) begin
        sv <= 1'b0;
      end
    end else if (arrive) begin
      if (!ov || take) begin
        ov <= 1'b1;
      end else begin
        sv <= 1'b1;
      end
    end else if (take) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sv) begin
      if (take) begin
        obuf <= sbuf;
      end
    end else if (arrive) begin
      if (!ov || take) begin
        obuf <= res;
      end else begin
        sbuf <= res;
      end
    end
  end

  assign stall    = sv;
  assign m_tvalid = ov;
  assign m_tuser  = obuf.status;
  assign m_tdata  = qpr_pkg::OUT_W'({obuf.saturated, obuf.imag_second, obuf.imag_first,
                                     obuf.real_second, obuf.real_first, obuf.root_count});

endmodule

>>> hdl/quadratic_polynomial_roots.sv
// quadratic root solver, one coefficient triple per cycle while the skid entry is empty
// pipeline: 3 front stages, 33 square root stages, 1 operand stage,
// 50 divider stages, 1 output register
// throughput: one transaction per cycle; the pipeline advances while the skid entry is empty
// reset: synchronous rst clears all valid bits; payload registers are not reset
// depends on qpr_pkg, qpr_front, qpr_sqrt, qpr_div, qpr_back
module quadratic_polynomial_roots (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [qpr_pkg::IN_W-1:0]  s_tdata,   // coef_a, coef_b, coef_c
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [qpr_pkg::OUT_W-1:0] m_tdata,   // root_count, real_first, real_second,
                                               // imag_first, imag_second, saturated, pad
  output logic [0:0]                m_tuser    // status
);

  logic                        ce, stall;
  logic                        fv, sqv;
  qpr_pkg::sq_ctx_t            fctx, sqctx;
  logic [qpr_pkg::DW-1:0]      frad;
  logic [qpr_pkg::RW-1:0]      sroot;

  logic                        pv;
  qpr_pkg::dv_ctx_t            pctx, pctx_next;
  logic [qpr_pkg::QMW-1:0]     n0, d0, n1, d1, qm, two_a;
  logic [qpr_pkg::NUMW-1:0]    num0, num1, q0, q1;
  logic [qpr_pkg::DENW-1:0]    den0, den1;

  logic                        dvv [0:qpr_pkg::DIV_STEPS];
  qpr_pkg::dv_ctx_t            dvc [0:qpr_pkg::DIV_STEPS];

  assign ce       = ~stall;
  assign s_tready = ce;

  qpr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .ce       (ce),
    .in_valid (s_tvalid),
    .coef_a   (s_tdata[qpr_pkg::CW-1:0]),
    .coef_b   (s_tdata[2*qpr_pkg::CW-1:qpr_pkg::CW]),
    .coef_c   (s_tdata[3*qpr_pkg::CW-1:2*qpr_pkg::CW]),
    .out_valid(fv),
    .out_ctx  (fctx),
    .out_rad  (frad)
  );

  qpr_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .ce       (ce),
    .in_valid (fv),
    .in_ctx   (fctx),
    .in_rad   (frad),
    .out_valid(sqv),
    .out_ctx  (sqctx),
    .out_root (sroot)
  );

  // divider operands by case
  always_comb begin
    qm    = qpr_pkg::QMW'(sqctx.mb) + qpr_pkg::QMW'(sroot);
    two_a = qpr_pkg::QMW'({sqctx.ma, 1'b0});
    n0 = '0;
    d0 = qpr_pkg::QMW'(1);
    n1 = '0;
    d1 = qpr_pkg::QMW'(1);
    pctx_next.na   = sqctx.na;
    pctx_next.nb   = sqctx.nb;
    pctx_next.neg0 = 1'b0;
    pctx_next.neg1 = 1'b0;
    pctx_next.cls  = sqctx.cls;
    if (sqctx.cls == qpr_pkg::CLS_QUAD) begin
      pctx_next.cls = sqctx.dneg ? qpr_pkg::CLS_CPLX : qpr_pkg::CLS_REAL;
    end
    unique case (pctx_next.cls)
      qpr_pkg::CLS_LINEAR: begin
        n0 = qpr_pkg::QMW'(sqctx.mc);
        d0 = qpr_pkg::QMW'(sqctx.mb);
        pctx_next.neg0 = (!sqctx.nc) != sqctx.nb;
      end
      qpr_pkg::CLS_REAL: begin
        n0 = qm;
        d0 = two_a;
        n1 = qpr_pkg::QMW'({sqctx.mc, 1'b0});
        d1 = qm;
        pctx_next.neg0 = (!sqctx.nb) != sqctx.na;
        pctx_next.neg1 = sqctx.nc != (!sqctx.nb);
      end
      qpr_pkg::CLS_CPLX: begin
        n0 = qpr_pkg::QMW'(sqctx.mb);
        d0 = two_a;
        n1 = qpr_pkg::QMW'(sroot);
        d1 = two_a;
        pctx_next.neg0 = (!sqctx.nb) != sqctx.na;
      end
      default: begin
        n0 = '0;
      end
    endcase
    pctx_next.dz1 = (d1 == '0);
  end

  // operand register
  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else if (ce) begin
      pv <= sqv;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      pctx <= pctx_next;
      num0 <= {n0, qpr_pkg::FB'(0)};
      den0 <= d0;
      num1 <= {n1, qpr_pkg::FB'(0)};
      den1 <= d1;
    end
  end

  qpr_div u_div0 (.clk(clk), .ce(ce), .num(num0), .den(den0), .quo(q0));
  qpr_div u_div1 (.clk(clk), .ce(ce), .num(num1), .den(den1), .quo(q1));

  // context delay line beside the dividers
  assign dvv[0] = pv;
  assign dvc[0] = pctx;

  for (genvar k = 0; k < qpr_pkg::DIV_STEPS; k++) begin : g_ctx
    always_ff @(posedge clk) begin
      if (rst) begin
        dvv[k+1] <= 1'b0;
      end else if (ce) begin
        dvv[k+1] <= dvv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        dvc[k+1] <= dvc[k];
      end
    end
  end

  qpr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (dvv[qpr_pkg::DIV_STEPS]),
    .in_ctx   (dvc[qpr_pkg::DIV_STEPS]),
    .q0       (q0),
    .q1       (q1),
    .stall    (stall),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

>>> hdl/qpr_checker.sv
// port-level checker for the quadratic root solver, bound to the top level
// depends on qpr_pkg and quadratic_polynomial_roots_macros.svh
`include "quadratic_polynomial_roots_macros.svh"

module qpr_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tvalid,
  input logic                      s_tready,
  input logic [qpr_pkg::IN_W-1:0]  s_tdata,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [qpr_pkg::OUT_W-1:0] m_tdata,
  input logic [0:0]                m_tuser
);

  logic       in_fire;
  logic [1:0] cnt;
  logic       all_zero;
  logic       extra_zero;

  assign in_fire    = s_tvalid & s_tready & (s_tdata == s_tdata);
  assign cnt        = m_tdata[1:0];
  // every field of the result, status aside
  assign all_zero   = (m_tdata[4*qpr_pkg::CW+2:0] == '0);
  // second real part and both imaginary parts
  assign extra_zero = (m_tdata[4*qpr_pkg::CW+1:qpr_pkg::CW+2] == '0);

  // a held result does not change
  `QPR_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "held result changed")

  // degenerate input reports no roots and empty fields
  `QPR_ASSERT_NOW(a_degen, m_tvalid && m_tuser[0], all_zero, "degenerate result not empty")

  // root count is never three
  `QPR_ASSERT_NOW(a_count, m_tvalid, cnt != 2'd3, "bad root count")

  // single root leaves second real and both imaginary fields zero
  `QPR_ASSERT_NOW(a_single, m_tvalid && cnt == 2'd1, extra_zero, "single root with extra fields")

  // no result appears right after reset
  `QPR_ASSERT_NEXT(a_reset, $fell(rst) && !in_fire, !m_tvalid, "result right after reset")

endmodule

bind quadratic_polynomial_roots qpr_checker u_qpr_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
